FILE: rtl/pow_pkg.sv
// Shared types, constants and helper functions of the nonce search block.
`default_nettype none
package pow_pkg;
	typedef logic [31:0] word_t;
	typedef word_t [7:0] hstate_t;

	localparam int IN_W  = 576;
	localparam int OUT_W = 296;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_TARGET_W0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_W1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_W2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_W3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NONCE_LIMIT = 3'd4;

	localparam word_t PAD_WORD = 32'h8000_0000;
	localparam word_t LEN_WORD = 32'd608;

	localparam word_t KROUND [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// Index 0 is word a.
	localparam hstate_t HINIT = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	function automatic word_t rotr(input word_t x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t swap32(input word_t x);
		swap32 = {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction
endpackage
`default_nettype wire

FILE: rtl/pow_wcell.sv
// One message schedule cell: holds one word and takes its neighbor's word each cycle that it is not loaded.
`default_nettype none
module pow_wcell (
	input  wire logic          clk,
	input  wire logic          ld,
	input  wire pow_pkg::word_t ld_word,
	input  wire pow_pkg::word_t nxt,
	output pow_pkg::word_t     q
);
	import pow_pkg::*;

	word_t w_q;

	// Load a fresh block word or take the neighbor's word.
	always_ff @(posedge clk) begin
		w_q <= ld ? ld_word : nxt;
	end

	assign q = w_q;
endmodule
`default_nettype wire

FILE: rtl/pow_round.sv
// One SHA-256 compression round over the working state.
`default_nettype none
module pow_round (
	input  wire pow_pkg::hstate_t v,
	input  wire pow_pkg::word_t   w,
	input  wire pow_pkg::word_t   k,
	output pow_pkg::hstate_t      nv
);
	import pow_pkg::*;

	word_t t1, t2, s0, s1, ch, maj;

	always_comb begin
		s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
		ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
		s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
		maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
		t1 = v[7] + s1 + ch + k + w;
		t2 = s0 + maj;
		nv[7] = v[6];
		nv[6] = v[5];
		nv[5] = v[4];
		nv[4] = v[3] + t1;
		nv[3] = v[2];
		nv[2] = v[1];
		nv[1] = v[0];
		nv[0] = t1 + t2;
	end
endmodule
`default_nettype wire

FILE: rtl/proof_of_work_nonce_search.sv
// Top level of the SHA-256 proof-of-work nonce search.
// One job per input transaction, one result per job. The job first compresses the
// fixed header block (64 rounds, then the add state), then tries nonces from zero until
// one is below the target or the nonce limit is reached; each nonce runs 64 rounds
// through the single round unit fed by a row of sixteen schedule cells, then the final
// add state and the target compare state. A new job is taken once the previous one
// has moved to the output register.
`default_nettype none
module proof_of_work_nonce_search (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	// payload length, content_hash_w0..w3, prev_hash_w0..w3, time_stamp
	input  wire logic [pow_pkg::IN_W-1:0]     s_tdata,
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	// found, winning_nonce, digest_w0..w3, zero fill
	output logic [pow_pkg::OUT_W-1:0]         m_tdata,
	input  wire logic                         cfg_we,
	input  wire logic [pow_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [pow_pkg::CFG_W-1:0]    cfg_data
);
	import pow_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RND  = 3'd1;
	localparam logic [2:0] ST_ADD  = 3'd2;
	localparam logic [2:0] ST_CMP  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0] state_q;
	logic [5:0] cnt_q;
	logic phase_q;
	logic [255:0] target_q;
	word_t limit_q;
	word_t nonce_q;
	word_t b2w0_q, b2w1_q;
	hstate_t v_q, mid_q, nv, sum;
	logic [255:0] dig_q;
	logic found_q;
	logic m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;

	logic ld;
	word_t ld_words [16];
	word_t wq [16];
	word_t wnext [16];
	word_t wnew, ld_nonce;
	logic accept, less;

	assign accept = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);

	// Schedule cell row.
	assign wnew = wq[0] + (rotr(wq[1], 7) ^ rotr(wq[1], 18) ^ (wq[1] >> 3)) + wq[9]
		+ (rotr(wq[14], 17) ^ rotr(wq[14], 19) ^ (wq[14] >> 10));

	for (genvar i = 0; i < 16; i++) begin : g_cell
		if (i == 15) begin : g_last
			assign wnext[i] = wnew;
		end else begin : g_mid
			assign wnext[i] = wq[i+1];
		end
		pow_wcell u_cell (
			.clk(clk), .ld(ld), .ld_word(ld_words[i]), .nxt(wnext[i]), .q(wq[i])
		);
	end

	pow_round u_round (.v(v_q), .w(wq[0]), .k(KROUND[cnt_q]), .nv(nv));

	// Select the words of the block to load.
	always_comb begin
		ld_nonce = (state_q == ST_CMP) ? nonce_q + 32'd1 : 32'd0;
		for (int i = 0; i < 16; i++) ld_words[i] = '0;
		if (state_q == ST_IDLE) begin
			ld_words[0] = swap32(s_tdata[31:0]);
			for (int i = 0; i < 8; i++) begin
				ld_words[1 + 2*i] = s_tdata[32 + 64*i + 32 +: 32];
				if (i < 7) ld_words[2 + 2*i] = s_tdata[32 + 64*i +: 32];
			end
		end else begin
			ld_words[0] = b2w0_q;
			ld_words[1] = b2w1_q;
			ld_words[2] = swap32(ld_nonce);
			ld_words[3] = PAD_WORD;
			ld_words[15] = LEN_WORD;
		end
		ld = accept || (state_q == ST_ADD && !phase_q) || (state_q == ST_CMP && !less
			&& nonce_q != limit_q - 32'd1);
	end

	// Add the working state into the chaining value.
	always_comb begin
		for (int i = 0; i < 8; i++) sum[i] = (phase_q ? mid_q[i] : HINIT[i]) + v_q[i];
	end

	assign less = dig_q < target_q;

	// Hold configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			limit_q <= '1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TARGET_W0: target_q[255:192] <= cfg_data;
				REG_TARGET_W1: target_q[191:128] <= cfg_data;
				REG_TARGET_W2: target_q[127:64] <= cfg_data;
				REG_TARGET_W3: target_q[63:0] <= cfg_data;
				REG_NONCE_LIMIT: limit_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// Sequence the job.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			phase_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (accept) begin
					cnt_q <= '0;
					phase_q <= 1'b0;
					state_q <= (limit_q == '0) ? ST_DONE : ST_RND;
				end
				ST_RND: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) state_q <= ST_ADD;
				end
				ST_ADD: begin
					phase_q <= 1'b1;
					state_q <= phase_q ? ST_CMP : ST_RND;
				end
				ST_CMP: state_q <= ld ? ST_RND : ST_DONE;
				ST_DONE: if (!m_tvalid_q || m_tready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Advance the datapath.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				v_q <= HINIT;
				b2w0_q <= s_tdata[511:480];
				b2w1_q <= swap32(s_tdata[575:544]);
				nonce_q <= '0;
				dig_q <= '0;
				found_q <= 1'b0;
			end
			ST_RND: v_q <= nv;
			ST_ADD: begin
				if (phase_q) begin
					dig_q <= {sum[0], sum[1], sum[2], sum[3], sum[4], sum[5], sum[6], sum[7]};
				end else begin
					mid_q <= sum;
					v_q <= sum;
				end
			end
			ST_CMP: begin
				found_q <= less;
				if (ld) begin
					nonce_q <= nonce_q + 32'd1;
					v_q <= mid_q;
				end
			end
			default: ;
		endcase
	end

	// Hold the result until the output transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_DONE && (!m_tvalid_q || m_tready)) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!m_tvalid_q || m_tready)) begin
			m_tdata_q <= {7'd0, dig_q[63:0], dig_q[127:64], dig_q[191:128], dig_q[255:192],
				nonce_q, found_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
endmodule
`default_nettype wire
